@@ design/pcapw_pkg.sv @@
`timescale 1ns / 1ps
package pcapw_pkg;

   // timestamp split: seconds = ns / 1e9, remainder carried 30 bits wide
   localparam int REM_W      = 30;
   localparam int QUO_W      = 35;
   localparam int DIV_STEPS  = 5;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;
   localparam logic [REM_W-1:0] NS_PER_S = 30'd1000000000;

   // usec = rem_ns * ceil(2^40 / 1000) >> 40, exact for rem_ns < 1e9
   localparam int RECIP_W    = 31;
   localparam int USEC_SHIFT = 40;
   localparam int USEC_W     = 20;
   localparam logic [RECIP_W-1:0] USEC_RECIP = 31'd1099511628;

   localparam logic [31:0] FILE_MAGIC     = 32'ha1b2c3d4;
   localparam logic [15:0] ETH_TYPE_IP    = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_TTL         = 8'd128;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
   localparam logic [5:0]  ENCAP_BYTES    = 6'd42;
   localparam logic [5:0]  GLOBAL_BYTES   = 6'd24;
   localparam logic [5:0]  RECORD_BYTES   = 6'd16;

   localparam logic [1:0] CSR_ENCAP    = 2'd0;
   localparam logic [1:0] CSR_SRC_PORT = 2'd1;
   localparam logic [1:0] CSR_DST_PORT = 2'd2;

   typedef struct packed {
      logic        req_type;
      logic        first_of_block;
      logic        has_byte;
      logic [7:0]  data_byte;
      logic [18:0] block_length;
   } pcapw_item_type;

   typedef struct packed {
      logic              req_type;
      logic              first_of_block;
      logic              has_byte;
      logic [7:0]        data_byte;
      logic [31:0]       sec;
      logic [USEC_W-1:0] usec;
      logic [19:0]       rec_len;
      logic [15:0]       ip_len;
      logic [15:0]       udp_len;
      logic [15:0]       cksum;
   } pcapw_rec_type;

endpackage

@@ design/pcap_udp_record_writer.sv @@
`timescale 1ns / 1ps
// Stages: 7 divide + 2 field stages, then the serializer register that drives rsp.
// Throughput: one item per cycle through the pipe while not held; the output side emits one byte
// per cycle while rsp_stall is low; an item makes 24, 16 or 58 header bytes, +1 payload byte.
// Payload-only items thus sustain one per cycle; header bursts hold the pipe at the serializer.
// Reset (synchronous, active high) empties all stages and loads register defaults.
module pcap_udp_record_writer #(
   parameter int SNAP_LENGTH = 262144
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_type,
   input  logic         req_first_of_block,
   input  logic [18:0]  req_block_length,
   input  logic [63:0]  req_stamp_ns,
   input  logic         req_has_byte,
   input  logic [7:0]   req_data_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last_of_item,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import pcapw_pkg::*;

   // configuration registers; write them only while the block is idle (a duty of the user, unchecked by the block)
   logic         encap_ff;
   logic [15:0]  src_port_ff;
   logic [15:0]  dst_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         encap_ff    <= 1'b0;
         src_port_ff <= 16'd443;
         dst_port_ff <= 16'd2368;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENCAP:    encap_ff    <= csr_wdata[0];
            CSR_SRC_PORT: src_port_ff <= csr_wdata;
            CSR_DST_PORT: dst_port_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // one shared enable: the whole pipe holds when its last stage cannot hand off
   logic pipe_en;
   logic fld_valid;
   logic ser_take;
   pcapw_rec_type fld_rec;

   assign pipe_en   = !fld_valid || ser_take;
   assign req_stall = !pipe_en;

   // seconds = ns / 1e9 by a restoring divider, DIV_STEPS quotient bits per stage.
   // the top 29 dividend bits are below 1e9, so they preload the remainder.
   logic                 stg_valid [0:DIV_STAGES];
   pcapw_item_type       stg_item  [0:DIV_STAGES];
   logic [REM_W-1:0]     stg_rem   [0:DIV_STAGES];
   logic [QUO_W-1:0]     stg_work  [0:DIV_STAGES];

   assign stg_valid[0]                = req_valid;
   assign stg_item[0].req_type        = req_type;
   assign stg_item[0].first_of_block  = req_first_of_block;
   assign stg_item[0].has_byte        = req_has_byte;
   assign stg_item[0].data_byte       = req_data_byte;
   assign stg_item[0].block_length    = req_block_length;
   assign stg_rem[0]                  = REM_W'(req_stamp_ns[63:QUO_W]);
   assign stg_work[0]                 = req_stamp_ns[QUO_W-1:0];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      pcapw_div_stage #(
         .STEPS(DIV_STEPS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (stg_valid[s]),
         .in_item   (stg_item[s]),
         .in_rem    (stg_rem[s]),
         .in_work   (stg_work[s]),
         .out_valid (stg_valid[s+1]),
         .out_item  (stg_item[s+1]),
         .out_rem   (stg_rem[s+1]),
         .out_work  (stg_work[s+1])
      );
   end

   // remainder ns -> usec by reciprocal multiply, then lengths and IP checksum
   pcapw_fields u_fields (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .encapsulate (encap_ff),
      .in_valid    (stg_valid[DIV_STAGES]),
      .in_item     (stg_item[DIV_STAGES]),
      .in_rem      (stg_rem[DIV_STAGES]),
      .in_sec      (stg_work[DIV_STAGES][31:0]),
      .out_valid   (fld_valid),
      .out_rec     (fld_rec)
   );

   // byte serializer: holds one item and walks its header and payload bytes
   pcapw_serializer #(
      .SNAP_LENGTH(SNAP_LENGTH)
   ) u_ser (
      .clock            (clock),
      .reset            (reset),
      .encapsulate      (encap_ff),
      .udp_source_port  (src_port_ff),
      .udp_dst_port     (dst_port_ff),
      .in_valid         (fld_valid),
      .in_rec           (fld_rec),
      .in_take          (ser_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // an empty serializer always frees the pipe
   a_empty_frees: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> pipe_en)
      else $error("pipe held while serializer empty");

   // a finished item waiting at the serializer is not lost while the pipe holds
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (fld_valid && !pipe_en) |=> fld_valid)
      else $error("held item dropped");

   // a byte not taken keeps its last marker
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_last_of_item))
      else $error("last marker changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");
endmodule

@@ design/pcapw_div_stage.sv @@
`timescale 1ns / 1ps
module pcapw_div_stage #(
   parameter int STEPS = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  pcapw_pkg::pcapw_item_type     in_item,
   input  logic [pcapw_pkg::REM_W-1:0]   in_rem,
   input  logic [pcapw_pkg::QUO_W-1:0]   in_work,
   output logic                          out_valid,
   output pcapw_pkg::pcapw_item_type     out_item,
   output logic [pcapw_pkg::REM_W-1:0]   out_rem,
   output logic [pcapw_pkg::QUO_W-1:0]   out_work
);
   import pcapw_pkg::*;

   logic                 valid_ff;
   pcapw_item_type       item_ff;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     work_ff, work_in;

   // restoring steps: dividend bits leave work at the top, quotient bits enter at the bottom
   always_comb begin
      logic [REM_W:0] t;
      logic           ge;
      rem_in  = in_rem;
      work_in = in_work;
      for (int i = 0; i < STEPS; i++) begin
         t  = {rem_in, work_in[QUO_W-1]};
         ge = (t >= {1'b0, NS_PER_S});
         rem_in  = ge ? REM_W'(t - {1'b0, NS_PER_S}) : REM_W'(t);
         work_in = {work_in[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff <= in_item;
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rem   = rem_ff;
   assign out_work  = work_ff;
endmodule

@@ design/pcapw_fields.sv @@
`timescale 1ns / 1ps
module pcapw_fields (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          encapsulate,
   input  logic                          in_valid,
   input  pcapw_pkg::pcapw_item_type     in_item,
   input  logic [pcapw_pkg::REM_W-1:0]   in_rem,
   input  logic [31:0]                   in_sec,
   output logic                          out_valid,
   output pcapw_pkg::pcapw_rec_type      out_rec
);
   import pcapw_pkg::*;

   localparam int PROD_W = REM_W + RECIP_W;

   logic                a_valid_ff;
   pcapw_item_type      a_item_ff;
   logic [31:0]         a_sec_ff;
   logic [PROD_W-1:0]   a_prod_ff, a_prod_in;

   logic                b_valid_ff;
   pcapw_rec_type       b_rec_ff, b_rec_in;

   assign a_prod_in = PROD_W'(in_rem) * PROD_W'(USEC_RECIP);

   always_comb begin
      logic [15:0] ip_len;
      logic [16:0] sum;
      logic [15:0] fold;
      ip_len = 16'(a_item_ff.block_length) + 16'd28;
      // header words other than total length: 4500 + 0001 + 8011 = c512
      sum  = {1'b0, ip_len} + 17'h0c512;
      fold = sum[15:0] + 16'(sum[16]);
      b_rec_in.req_type       = a_item_ff.req_type;
      b_rec_in.first_of_block = a_item_ff.first_of_block;
      b_rec_in.has_byte       = a_item_ff.has_byte;
      b_rec_in.data_byte      = a_item_ff.data_byte;
      b_rec_in.sec            = a_sec_ff;
      b_rec_in.usec           = a_prod_ff[USEC_SHIFT+USEC_W-1:USEC_SHIFT];
      b_rec_in.rec_len        = 20'(a_item_ff.block_length) +
                                (encapsulate ? 20'(ENCAP_BYTES) : 20'd0);
      b_rec_in.ip_len         = ip_len;
      b_rec_in.udp_len        = 16'(a_item_ff.block_length) + 16'd8;
      b_rec_in.cksum          = ~fold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         a_item_ff <= in_item;
         a_sec_ff  <= in_sec;
         a_prod_ff <= a_prod_in;
         b_rec_ff  <= b_rec_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rec   = b_rec_ff;
endmodule

@@ design/pcapw_serializer.sv @@
`timescale 1ns / 1ps
module pcapw_serializer #(
   parameter int SNAP_LENGTH = 262144
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       encapsulate,
   input  logic [15:0]                udp_source_port,
   input  logic [15:0]                udp_dst_port,
   input  logic                       in_valid,
   input  pcapw_pkg::pcapw_rec_type   in_rec,
   output logic                       in_take,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last_of_item
);
   import pcapw_pkg::*;

   localparam logic [31:0] SNAP = 32'(SNAP_LENGTH);

   logic            valid_ff, valid_in;
   pcapw_rec_type   rec_ff;
   logic [5:0]      cnt_ff, cnt_in;
   logic [5:0]      hdr_ff;
   logic [5:0]      total_ff;
   logic [5:0]      new_hdr, new_total;
   logic            out_done;

   function automatic logic [7:0] global_byte(input logic [5:0] i);
      logic [7:0] b;
      case (i)
         6'd0:    b = FILE_MAGIC[7:0];
         6'd1:    b = FILE_MAGIC[15:8];
         6'd2:    b = FILE_MAGIC[23:16];
         6'd3:    b = FILE_MAGIC[31:24];
         6'd4:    b = 8'd2;
         6'd6:    b = 8'd4;
         6'd16:   b = SNAP[7:0];
         6'd17:   b = SNAP[15:8];
         6'd18:   b = SNAP[23:16];
         6'd19:   b = SNAP[31:24];
         6'd20:   b = 8'd1;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] block_byte(input logic [5:0] i, input pcapw_rec_type r,
                                             input logic [15:0] sp, input logic [15:0] dp);
      logic [7:0]  b;
      logic [31:0] us, rl;
      us = 32'(r.usec);
      rl = 32'(r.rec_len);
      case (i)
         6'd0:    b = r.sec[7:0];
         6'd1:    b = r.sec[15:8];
         6'd2:    b = r.sec[23:16];
         6'd3:    b = r.sec[31:24];
         6'd4:    b = us[7:0];
         6'd5:    b = us[15:8];
         6'd6:    b = us[23:16];
         6'd7:    b = us[31:24];
         6'd8,
         6'd12:   b = rl[7:0];
         6'd9,
         6'd13:   b = rl[15:8];
         6'd10,
         6'd14:   b = rl[23:16];
         6'd11,
         6'd15:   b = rl[31:24];
         6'd28:   b = ETH_TYPE_IP[15:8];
         6'd29:   b = ETH_TYPE_IP[7:0];
         6'd30:   b = IP_VER_IHL;
         6'd32:   b = r.ip_len[15:8];
         6'd33:   b = r.ip_len[7:0];
         6'd35:   b = 8'd1;          // IP id
         6'd38:   b = IP_TTL;
         6'd39:   b = IP_PROTO_UDP;
         6'd40:   b = r.cksum[15:8];
         6'd41:   b = r.cksum[7:0];
         6'd50:   b = sp[15:8];
         6'd51:   b = sp[7:0];
         6'd52:   b = dp[15:8];
         6'd53:   b = dp[7:0];
         6'd54:   b = r.udp_len[15:8];
         6'd55:   b = r.udp_len[7:0];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   always_comb begin
      if (!in_rec.req_type) begin
         new_hdr = GLOBAL_BYTES;
      end else if (in_rec.first_of_block) begin
         new_hdr = encapsulate ? RECORD_BYTES + ENCAP_BYTES : RECORD_BYTES;
      end else begin
         new_hdr = 6'd0;
      end
      new_total = new_hdr + 6'((in_rec.req_type && in_rec.has_byte) ? 1 : 0);
   end

   assign rsp_last_of_item = (cnt_ff == total_ff - 6'd1);
   assign out_done = valid_ff && !rsp_stall && rsp_last_of_item;
   assign in_take  = !valid_ff || out_done;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (in_take) begin
         // items that emit nothing are dropped here
         valid_in = in_valid && (new_total != 6'd0);
         cnt_in   = 6'd0;
      end else if (!rsp_stall) begin
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= 6'd0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      if (in_take) begin
         rec_ff   <= in_rec;
         hdr_ff   <= new_hdr;
         total_ff <= new_total;
      end
   end

   always_comb begin
      if (cnt_ff >= hdr_ff) begin
         rsp_out_byte = rec_ff.data_byte;
      end else if (!rec_ff.req_type) begin
         rsp_out_byte = global_byte(cnt_ff);
      end else begin
         rsp_out_byte = block_byte(cnt_ff, rec_ff, udp_source_port, udp_dst_port);
      end
   end

   assign rsp_valid = valid_ff;
endmodule
